// ----- src/box3_pkg.sv -----
// Shared types and constants for the 3x3 box filter.
// Used by the control, RAM, window cell and top-level modules; depends on nothing.
`default_nettype none

package box3_pkg;

  localparam int PIX_W = 24;
  localparam int WIN_N = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // One column of the 3x3 window: top is two rows up, bot is the newest row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Per-channel sum of one window column.
  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } csum_t;

  // Per-channel sum of the whole window.
  typedef struct packed {
    logic [11:0] r;
    logic [11:0] g;
    logic [11:0] b;
  } tsum_t;

  // Decisions made for an item when it is accepted.
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
    logic up_en;
    logic lo_en;
  } item_ctl_t;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

endpackage

`default_nettype wire

// ----- src/box3_ram.sv -----
// Simple dual-port line buffer memory: one write and one registered read per cycle.
// Depends on box3_pkg for the pixel type.
`default_nettype none

module box3_ram #(
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire box3_pkg::pix_t             wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output box3_pkg::pix_t                  rdata
);
  import box3_pkg::*;

  pix_t mem_r [DEPTH];
  pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/box3_cell.sv -----
// One column cell of the 3x3 window, taking a column from its right neighbour.
// Depends on box3_pkg for the column and sum types.
`default_nettype none

module box3_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire box3_pkg::col_t col_in,
  output box3_pkg::col_t     col_q,
  output box3_pkg::csum_t    sum_q
);
  import box3_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (en) begin
      col_r <= col_in;
    end
  end

  assign col_q   = col_r;
  assign sum_q.r = 10'(col_r.top[23:16]) + 10'(col_r.mid[23:16]) + 10'(col_r.bot[23:16]);
  assign sum_q.g = 10'(col_r.top[15:8])  + 10'(col_r.mid[15:8])  + 10'(col_r.bot[15:8]);
  assign sum_q.b = 10'(col_r.top[7:0])   + 10'(col_r.mid[7:0])   + 10'(col_r.bot[7:0]);

endmodule

`default_nettype wire

// ----- src/box3_ctrl.sv -----
// Configuration registers and raster position counters of the box filter.
// Decides per accepted word whether it yields a result and whether that is a border pixel.
// Depends on box3_pkg.
`default_nettype none

module box3_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [box3_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [box3_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 acc,
  output logic [$clog2(MAX_WIDTH)-1:0]              rd_col,
  output box3_pkg::item_ctl_t                       ctl
);
  import box3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
  localparam int HW = HEIGHT_REG_W + 1;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic [EW-1:0] width_ext, eff_w, in_col_inc, out_col_inc;
  logic [HW-1:0] eff_h, out_row_inc;
  logic          in_wrap, out_col_end, out_row_end;

  always_comb begin
    width_ext = EW'(width_r);
    priority if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
  end

  assign eff_h       = (height_r == '0) ? HW'(1) : {1'b0, height_r};
  assign in_col_inc  = EW'(in_col_r) + EW'(1);
  assign out_col_inc = EW'(out_col_r) + EW'(1);
  assign out_row_inc = {1'b0, out_row_r} + HW'(1);
  assign in_wrap     = in_col_inc >= eff_w;
  assign out_col_end = out_col_inc >= eff_w;
  assign out_row_end = out_row_inc >= eff_h;

  // A result is due once a full row plus one pixel has gone in.
  assign ctl.emit   = (in_row_r >= 16'd2) || ((in_row_r == 16'd1) && (in_col_r != '0));
  assign ctl.border = (out_row_r == '0) || out_row_end || (out_col_r == '0) || out_col_end;
  assign ctl.last   = out_row_end && out_col_end;
  assign ctl.up_en  = in_row_r >= 16'd2;
  assign ctl.lo_en  = in_row_r != '0;
  assign rd_col     = in_col_r;

  always_comb begin
    in_col_nxt  = in_wrap ? '0 : in_col_r + CW'(1);
    in_row_nxt  = (in_wrap && (in_row_r != '1)) ? in_row_r + 16'd1 : in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (ctl.emit) begin
      priority if (ctl.last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 16'd1;
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_REG_W-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/box_filter_3x3_smoothing.sv -----
// 3x3 box filter over a raster RGB stream. The word completing a window passes stage 1, the
// window cells, sums and output register (one row plus one pixel behind the input).
// Throughput: one word per cycle; the whole pipeline holds only while out_tready is low.
// Reset (synchronous, rst_n low) clears counters, window and valid flags and loads
// width 640 and height 480; the line buffers are not cleared, so there is no clearing pass.
// Depends on box3_pkg, box3_ctrl, box3_ram and box3_cell.
`default_nettype none

module box_filter_3x3_smoothing #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [box3_pkg::PIX_W-1:0]           in_tdata,   // pixel_in[23:0]
  input  wire logic                                 in_tuser,   // is_pad
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [box3_pkg::PIX_W-1:0]                out_tdata,  // pixel_out[23:0]
  output logic                                      out_tlast,
  input  wire logic                                 cfg_we,
  input  wire logic [box3_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [box3_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import box3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [12:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  // Exact floor(s / 9) for any window sum up to 9 * 255, by a scaled reciprocal.
  function automatic logic [7:0] div9(input logic [11:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'(DIV9_MUL);
    return p[DIV9_SHIFT +: 8];
  endfunction

  logic      adv, acc;
  logic [CW-1:0] rd_col;
  item_ctl_t ctl;

  logic          s1_valid_r, s1_fwd_r;
  pix_t          s1_px_r, fwd_lo_r, fwd_up_r;
  logic [CW-1:0] s1_col_r;
  item_ctl_t     s1_ctl_r;
  pix_t          rd_lo, rd_up, lo1, up1;
  logic          fwd_hit, win_en;

  logic          s2_emit_r, s2_border_r, s2_last_r;
  logic          s3_emit_r, s3_border_r, s3_last_r;
  tsum_t         s3_sum_r;
  pix_t          s3_center_r;

  logic          out_valid_r, out_last_r;
  pix_t          out_pix_r;

  col_t          chain_in [WIN_N];
  col_t          col_q    [WIN_N];
  csum_t         sum_q    [WIN_N];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  box3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .acc      (acc),
    .rd_col   (rd_col),
    .ctl      (ctl)
  );

  // The word in stage 1 writes its column at the same edge the next word reads;
  // when both hit the same column the read would miss the write, so forward it.
  assign fwd_hit = s1_valid_r && (s1_col_r == rd_col);
  assign win_en  = adv && s1_valid_r;
  assign lo1     = !s1_ctl_r.lo_en ? '0 : (s1_fwd_r ? fwd_lo_r : rd_lo);
  assign up1     = !s1_ctl_r.up_en ? '0 : (s1_fwd_r ? fwd_up_r : rd_up);

  box3_ram #(.DEPTH(MAX_WIDTH)) u_lb_lower (
    .clk   (clk),
    .we    (win_en),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (acc),
    .raddr (rd_col),
    .rdata (rd_lo)
  );

  box3_ram #(.DEPTH(MAX_WIDTH)) u_lb_upper (
    .clk   (clk),
    .we    (win_en),
    .waddr (s1_col_r),
    .wdata (lo1),
    .re    (acc),
    .raddr (rd_col),
    .rdata (rd_up)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r  <= in_tuser ? '0 : in_tdata;
      s1_col_r <= rd_col;
      s1_ctl_r <= ctl;
      s1_fwd_r <= fwd_hit;
      fwd_lo_r <= s1_px_r;
      fwd_up_r <= lo1;
    end
  end

  // Window: a row of column cells, the newest column entering at the right.
  assign chain_in[WIN_N-1] = '{top: up1, mid: lo1, bot: s1_px_r};

  for (genvar g = 0; g < WIN_N - 1; g++) begin : g_link
    assign chain_in[g] = col_q[g+1];
  end

  for (genvar g = 0; g < WIN_N; g++) begin : g_cell
    box3_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (win_en),
      .col_in (chain_in[g]),
      .col_q  (col_q[g]),
      .sum_q  (sum_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_emit_r <= 1'b0;
      s3_emit_r <= 1'b0;
    end else if (adv) begin
      s2_emit_r <= s1_valid_r && s1_ctl_r.emit;
      s3_emit_r <= s2_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_border_r <= s1_ctl_r.border;
      s2_last_r   <= s1_ctl_r.last;
      s3_border_r <= s2_border_r;
      s3_last_r   <= s2_last_r;
      s3_center_r <= col_q[1].mid;
      s3_sum_r.r  <= 12'(sum_q[0].r) + 12'(sum_q[1].r) + 12'(sum_q[2].r);
      s3_sum_r.g  <= 12'(sum_q[0].g) + 12'(sum_q[1].g) + 12'(sum_q[2].g);
      s3_sum_r.b  <= 12'(sum_q[0].b) + 12'(sum_q[1].b) + 12'(sum_q[2].b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix_r  <= s3_border_r ? s3_center_r
                                : {div9(s3_sum_r.r), div9(s3_sum_r.g), div9(s3_sum_r.b)};
      out_last_r <= s3_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- src/box3_chk.sv -----
// Port-level checks for the box filter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module box3_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word present after reset");

  // With the output register empty the block is always ready for a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // A blocked output word holds back the input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output is blocked");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output word changed");

endmodule

bind box_filter_3x3_smoothing box3_chk u_box3_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
